[rtl/sfpr_pkg.sv]
// shared types, codes and the size class function of the free page run pool
package sfpr_pkg;

	localparam int WORD_W           = 32;
	localparam int POOL_SLOTS_DEF   = 64;
	localparam int SIZE_CLASSES_DEF = 32;
	localparam int CLS_MAX_W        = 5;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_GET = 1'b1;

	typedef enum logic [2:0] {
		STS_DONE = 3'd0,
		STS_NONE = 3'd1,
		STS_DUP  = 3'd2,
		STS_FULL = 3'd3,
		STS_ZERO = 3'd4
	} status_t;

	typedef struct packed {
		logic [WORD_W-1:0] start;
		logic [WORD_W-1:0] count;
	} slot_t;

	// per-cycle strobes from the sequencer to every cell
	typedef struct packed {
		logic cmp;
		logic remove;
		logic load;
	} cell_ctrl_t;

	// floor(log2(n)), zero for n of zero, capped at top
	function automatic logic [CLS_MAX_W-1:0] size_class(input logic [WORD_W-1:0] n,
			input logic [CLS_MAX_W-1:0] top);
		logic [CLS_MAX_W-1:0] c;
		c = '0;
		for (int i = 1; i < WORD_W; i++) begin
			if (n[i]) begin
				c = CLS_MAX_W'(i);
			end
		end
		if (c > top) begin
			c = top;
		end
		return c;
	endfunction

endpackage

[rtl/sfpr_cell.sv]
// one slot of the run pool: holds a run, compares it and shifts toward the head
module sfpr_cell import sfpr_pkg::*; #(
	parameter int IDX = 0,
	parameter int UW  = 7,
	parameter int CW  = 5,
	parameter int NC  = 32
) (
	input  logic          clk,
	input  cell_ctrl_t    ctrl,
	input  logic [UW-1:0] used,
	input  slot_t         req,
	input  logic [CW-1:0] req_cls,
	input  logic [CW-1:0] sel_cls,
	input  slot_t         nxt,
	input  logic [CW-1:0] nxt_cls,
	input  logic          seen_in,
	output slot_t         cur,
	output logic [CW-1:0] cur_cls,
	output logic [NC-1:0] cls_vec,
	output logic          dup,
	output logic          seen_out,
	output slot_t         grant
);

	slot_t         slot_q;
	logic [CW-1:0] cls_q;
	logic          dup_s1;
	logic          cand_s1;
	logic          occupied;
	logic          hit;

	assign occupied = used > UW'(IDX);
	assign hit      = cand_s1 && (cls_q == sel_cls);
	assign seen_out = seen_in | hit;

	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			dup_s1  <= occupied && (slot_q.start == req.start);
			cand_s1 <= occupied && (slot_q.count >= req.count) && (cls_q >= req_cls);
		end
		// removal closes the gap: this cell and all younger ones take the next slot
		if (ctrl.remove && seen_out) begin
			slot_q <= nxt;
			cls_q  <= nxt_cls;
		end else if (ctrl.load && (used == UW'(IDX))) begin
			slot_q <= req;
			cls_q  <= req_cls;
		end
	end

	assign cur     = slot_q;
	assign cur_cls = cls_q;
	assign cls_vec = cand_s1 ? (NC'(1) << cls_q) : '0;
	assign dup     = dup_s1;
	// only the oldest matching cell hands out its run
	assign grant   = (hit && !seen_in) ? slot_q : '0;

endmodule

[rtl/segregated_free_page_run_pool.sv]
// top level of the segregated free page run pool: sequencer, request and result registers
// the result word is registered once the compare, class pick and act steps are through, in that order
// a new word is taken only while idle, after compare, class pick and act of the last word
// the act step stalls while an earlier result still waits in the output register
// the output register lets the next word be taken while a result waits
// reset: pool empty, pool_enable set, no result pending; no clearing pass is needed
module segregated_free_page_run_pool import sfpr_pkg::*; #(
	parameter int POOL_SLOTS   = POOL_SLOTS_DEF,
	parameter int SIZE_CLASSES = SIZE_CLASSES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                command,
	input  logic [WORD_W-1:0]   start_page,
	input  logic [WORD_W-1:0]   page_count,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [2:0]          status,
	output logic [WORD_W-1:0]   granted_start,
	output logic [WORD_W-1:0]   granted_count
);

	localparam int UW = $clog2(POOL_SLOTS + 1);
	localparam int CW = $clog2(SIZE_CLASSES);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_CMP  = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_ACT  = 4'b1000
	} fsm_t;

	fsm_t          st_q;
	logic          pool_enable_q;
	logic [UW-1:0] used_q;

	// request registers
	logic          req_cmd_q;
	slot_t         req_q;
	logic [CW-1:0] req_cls_q;
	logic [CW-1:0] sel_cls_q;

	// result register
	logic              out_valid_q;
	status_t           status_q;
	slot_t             grant_q;

	// chain wiring
	cell_ctrl_t        ctrl;
	slot_t             cell_cur   [POOL_SLOTS];
	logic [CW-1:0]     cell_cls   [POOL_SLOTS];
	logic [SIZE_CLASSES-1:0] cell_vec [POOL_SLOTS];
	slot_t             cell_grant [POOL_SLOTS];
	logic [POOL_SLOTS-1:0] cell_dup;
	logic [POOL_SLOTS-1:0] seen_chain;

	logic              act_go;
	logic              dup_any;
	logic              hit_any;
	logic              add_ok;
	logic              get_ok;
	logic [SIZE_CLASSES-1:0] class_vec;
	logic [CW-1:0]     low_cls;
	slot_t             grant_any;
	status_t           status_d;

	assign in_ready = (st_q == ST_IDLE);

	// the act step waits while an earlier result is still in the output register
	assign act_go = (st_q == ST_ACT) && (!out_valid_q || out_ready);

	assign dup_any = |cell_dup;
	// the end of the chain tells whether any cell matched the chosen class
	assign hit_any = seen_chain[POOL_SLOTS-1];

	assign add_ok = pool_enable_q && (req_cmd_q == CMD_ADD) && !dup_any
		&& (req_q.count != '0) && (used_q < UW'(POOL_SLOTS));
	assign get_ok = pool_enable_q && (req_cmd_q == CMD_GET)
		&& (req_q.count != '0) && hit_any;

	assign ctrl.cmp    = (st_q == ST_CMP);
	assign ctrl.remove = act_go && get_ok;
	assign ctrl.load   = act_go && add_ok;

	// classes that hold at least one fitting run, the lowest of them, and the run granted by the chain
	always_comb begin
		class_vec = '0;
		grant_any = '0;
		for (int i = 0; i < POOL_SLOTS; i++) begin
			class_vec = class_vec | cell_vec[i];
			grant_any = grant_any | cell_grant[i];
		end
		low_cls = '0;
		for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
			if (class_vec[c]) begin
				low_cls = CW'(c);
			end
		end
	end

	// status of an add in check order: disabled, duplicate, zero length, full; a get is done or finds none
	always_comb begin
		status_d = STS_NONE;
		if (pool_enable_q) begin
			if (req_cmd_q == CMD_ADD) begin
				priority if (dup_any) begin
					status_d = STS_DUP;
				end else if (req_q.count == '0) begin
					status_d = STS_ZERO;
				end else if (used_q >= UW'(POOL_SLOTS)) begin
					status_d = STS_FULL;
				end else begin
					status_d = STS_DONE;
				end
			end else if (get_ok) begin
				status_d = STS_DONE;
			end
		end
	end

	// row of slot cells, each handing its run to the older neighbor on removal
	for (genvar i = 0; i < POOL_SLOTS; i++) begin : g_cell
		slot_t         nxt;
		logic [CW-1:0] nxt_cls;
		logic          seen_in;

		if (i == POOL_SLOTS - 1) begin : g_tail
			assign nxt     = '0;
			assign nxt_cls = '0;
		end else begin : g_body
			assign nxt     = cell_cur[i+1];
			assign nxt_cls = cell_cls[i+1];
		end

		if (i == 0) begin : g_head
			assign seen_in = 1'b0;
		end else begin : g_link
			assign seen_in = seen_chain[i-1];
		end

		sfpr_cell #(
			.IDX (i),
			.UW  (UW),
			.CW  (CW),
			.NC  (SIZE_CLASSES)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.used     (used_q),
			.req      (req_q),
			.req_cls  (req_cls_q),
			.sel_cls  (sel_cls_q),
			.nxt      (nxt),
			.nxt_cls  (nxt_cls),
			.seen_in  (seen_in),
			.cur      (cell_cur[i]),
			.cur_cls  (cell_cls[i]),
			.cls_vec  (cell_vec[i]),
			.dup      (cell_dup[i]),
			.seen_out (seen_chain[i]),
			.grant    (cell_grant[i])
		);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q          <= ST_IDLE;
			pool_enable_q <= 1'b1;
			used_q        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				pool_enable_q <= cfg_wdata;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					st_q <= ST_SEL;
				end
				ST_SEL: begin
					st_q <= ST_ACT;
				end
				ST_ACT: begin
					if (act_go) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (ctrl.load) begin
				used_q <= used_q + UW'(1);
			end else if (ctrl.remove) begin
				used_q <= used_q - UW'(1);
			end
			if (act_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_cmd_q   <= command;
			req_q.start <= start_page;
			req_q.count <= page_count;
			req_cls_q   <= CW'(size_class(page_count, CLS_MAX_W'(SIZE_CLASSES - 1)));
		end
		if (st_q == ST_SEL) begin
			sel_cls_q <= low_cls;
		end
		if (act_go) begin
			status_q <= status_d;
			grant_q  <= get_ok ? grant_any : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_start = grant_q.start;
	assign granted_count = grant_q.count;

endmodule
